@@ design/rtmp_chunk_deframer_top_macros.svh @@
// Assertion macros used by the checker file rcd_checker.sv.
`ifndef RTMP_CHUNK_DEFRAMER_TOP_MACROS_SVH
`define RTMP_CHUNK_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcd check failed");

// Next-cycle implication.
`define RCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcd check failed");

`endif

@@ design/rcd_pkg.sv @@
`timescale 1ns / 1ps
package rcd_pkg;

    localparam int CSID_SLOTS_DEF = 64;
    localparam int CS_W           = 17;
    localparam int TDATA_W        = 152;

    localparam logic [23:0] CHUNK_MAX_RST  = 24'd128;
    localparam logic [31:0] STAMP_EXT      = 32'h00ff_ffff;
    localparam logic [23:0] TIME_EXT       = 24'hff_ffff;
    localparam logic [CS_W-1:0] CS_BASE    = 17'd64;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [23:0] length;
        logic [23:0] offset;
        logic [7:0]  mtype;
        logic [31:0] stream;
        logic [31:0] stamp;
        logic [31:0] extended;
        logic [31:0] mtime;
    } t_ctx;

    localparam int CTX_W = $bits(t_ctx);

    typedef struct packed {
        t_kind           kind;
        logic [CS_W-1:0] chunk_stream;
        logic [7:0]      payload_byte;
        logic [23:0]     byte_offset;
        logic            last;
        logic [23:0]     message_length;
        logic [7:0]      message_type;
        logic [31:0]     message_stream;
        logic [31:0]     message_time;
    } t_result;

    function automatic logic [3:0] hdr_len(input logic [1:0] fmt);
        case (fmt)
            2'd0:    hdr_len = 4'd11;
            2'd1:    hdr_len = 4'd7;
            2'd2:    hdr_len = 4'd3;
            default: hdr_len = 4'd0;
        endcase
    endfunction

endpackage

@@ design/rtmp_chunk_deframer_top.sv @@
`timescale 1ns / 1ps
// A result leaves the output register in the cycle after the byte that causes it;
// an empty message closed by a format-3 header is formed later, in the lookup phase.
// Throughput: one byte per cycle while the output is not stalled; a format-3 basic header
// holds off the next byte for the lookup phase, while the context is read from the slot RAM.
// Reset (synchronous, active low) clears parser state, chunk size to 128 and all
// slot valid bits at once, so every context reads as zero; no clearing pass.
module rtmp_chunk_deframer_top
    import rcd_pkg::*;
#(
    parameter int CSID_SLOTS = CSID_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [23:0]        i_cfg_data,     // max payload bytes per chunk
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,      // data_byte
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // chunk_stream, payload_byte, byte_offset, message_length, message_type,
    // message_stream, message_time, zero pad
    output logic [TDATA_W-1:0] o_m_tdata,
    output logic [1:0]         o_m_tuser,      // result_kind
    output logic               o_m_tlast       // last
);

    localparam int AW = $clog2(CSID_SLOTS);

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [CTX_W-1:0] rd_data, wr_data;
    t_result       out;

    rcd_ram #(.WIDTH(CTX_W), .DEPTH(CSID_SLOTS)) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    rcd_parser #(.CSID_SLOTS(CSID_SLOTS)) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_in_byte   (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out       (out),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tuser   = out.kind;
    assign o_m_tlast   = out.last;
    assign o_m_tdata   = {7'd0, out.message_time, out.message_stream, out.message_type,
                          out.message_length, out.byte_offset, out.payload_byte,
                          out.chunk_stream};

endmodule

@@ design/rcd_ram.sv @@
`timescale 1ns / 1ps
module rcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rcd_parser.sv @@
`timescale 1ns / 1ps
module rcd_parser
    import rcd_pkg::*;
#(
    parameter int CSID_SLOTS = CSID_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [23:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output t_result                       o_out,
    output logic                          o_rd_en,
    output logic [$clog2(CSID_SLOTS)-1:0] o_rd_addr,
    input  logic [CTX_W-1:0]              i_rd_data,
    output logic                          o_wr_en,
    output logic [$clog2(CSID_SLOTS)-1:0] o_wr_addr,
    output logic [CTX_W-1:0]              o_wr_data
);

    localparam int AW = $clog2(CSID_SLOTS);

    typedef enum logic [3:0] {
        PH_BASIC, PH_ID2, PH_ID3A, PH_ID3B, PH_LOOKUP, PH_MSG, PH_EXT, PH_BODY, PH_HALT
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [3:0]      r_cnt, n_cnt;
    logic [1:0]      r_fmt, n_fmt;
    logic [23:0]     r_htime, n_htime;
    logic [23:0]     r_hlen, n_hlen;
    logic [7:0]      r_htype, n_htype;
    logic [31:0]     r_hstream, n_hstream;
    logic [31:0]     r_hext, n_hext;
    logic [CS_W-1:0] r_cs, n_cs;
    logic [23:0]     r_left, n_left;
    t_ctx            r_ctx, n_ctx;
    logic            r_ld, n_ld;
    logic            r_rd_ok;
    logic [CSID_SLOTS-1:0] r_valid;
    logic [23:0]     r_csize;
    logic            r_ovalid;
    t_result         r_out;

    logic            space;
    logic            step;
    logic            res_v;
    t_result         res;
    logic            wr;
    logic            fin_basic, fin_msg, fin_hdr;
    logic [23:0]     remain, lim;
    logic [31:0]     add;
    logic [24:0]     off_nx;

    assign space      = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_phase == PH_HALT) || ((r_phase != PH_LOOKUP) && space);
    assign step       = (r_phase == PH_LOOKUP) ? space : (i_in_valid && o_in_ready);

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_fmt     = r_fmt;
        n_htime   = r_htime;
        n_hlen    = r_hlen;
        n_htype   = r_htype;
        n_hstream = r_hstream;
        n_hext    = r_hext;
        n_cs      = r_cs;
        n_left    = r_left;
        n_ctx     = r_ld ? (r_rd_ok ? t_ctx'(i_rd_data) : '0) : r_ctx;
        n_ld      = 1'b0;
        o_rd_en   = 1'b0;
        wr        = 1'b0;
        res_v     = 1'b0;
        res       = '0;
        fin_basic = 1'b0;
        fin_msg   = 1'b0;
        fin_hdr   = 1'b0;
        remain    = '0;
        lim       = '0;
        add       = '0;
        off_nx    = '0;
        if (step) begin
            case (r_phase)
                PH_BASIC: begin
                    n_fmt     = i_in_byte[7:6];
                    n_htime   = '0;
                    n_hlen    = '0;
                    n_htype   = '0;
                    n_hstream = '0;
                    n_hext    = '0;
                    n_cs      = {{(CS_W-6){1'b0}}, i_in_byte[5:0]};
                    if (i_in_byte[5:0] == 6'd0) begin
                        n_phase = PH_ID2;
                    end else if (i_in_byte[5:0] == 6'd1) begin
                        n_phase = PH_ID3A;
                    end else begin
                        fin_basic = 1'b1;
                    end
                end
                PH_ID2: begin
                    n_cs      = CS_BASE + CS_W'(i_in_byte);
                    fin_basic = 1'b1;
                end
                PH_ID3A: begin
                    n_cs    = CS_BASE + CS_W'(i_in_byte);
                    n_phase = PH_ID3B;
                end
                PH_ID3B: begin
                    n_cs      = r_cs + {1'b0, i_in_byte, 8'd0};
                    fin_basic = 1'b1;
                end
                PH_LOOKUP: begin
                    fin_msg = 1'b1;
                end
                PH_MSG: begin
                    case (r_cnt)
                        4'd0, 4'd1, 4'd2: n_htime = {r_htime[15:0], i_in_byte};
                        4'd3, 4'd4, 4'd5: n_hlen  = {r_hlen[15:0], i_in_byte};
                        4'd6:  n_htype = i_in_byte;
                        4'd7:  n_hstream[7:0]   = i_in_byte;
                        4'd8:  n_hstream[15:8]  = i_in_byte;
                        4'd9:  n_hstream[23:16] = i_in_byte;
                        4'd10: n_hstream[31:24] = i_in_byte;
                        default: ;
                    endcase
                    n_cnt = r_cnt + 4'd1;
                    if (n_cnt >= hdr_len(r_fmt)) begin
                        fin_msg = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_hext = {r_hext[23:0], i_in_byte};
                    n_cnt  = r_cnt + 4'd1;
                    if (n_cnt >= 4'd4) begin
                        fin_hdr = 1'b1;
                    end
                end
                PH_BODY: begin
                    off_nx           = {1'b0, n_ctx.offset} + 25'd1;
                    res.payload_byte = i_in_byte;
                    res.byte_offset  = n_ctx.offset;
                    res.chunk_stream = r_cs;
                    res.kind         = KIND_PAYLOAD;
                    res_v            = 1'b1;
                    n_ctx.offset     = off_nx[23:0];
                    n_left           = r_left - 24'd1;
                    if (off_nx >= {1'b0, n_ctx.length}) begin
                        add = (n_ctx.stamp >= STAMP_EXT) ? n_ctx.extended : n_ctx.stamp;
                        n_ctx.mtime        = n_ctx.mtime + add;
                        res.last           = 1'b1;
                        res.message_length = n_ctx.length;
                        res.message_type   = n_ctx.mtype;
                        res.message_stream = n_ctx.stream;
                        res.message_time   = n_ctx.mtime;
                        n_ctx.offset       = '0;
                        n_ctx.stamp        = '0;
                        n_ctx.extended     = '0;
                        n_phase            = PH_BASIC;
                        wr                 = 1'b1;
                    end else if (n_left == 24'd0) begin
                        n_phase = PH_BASIC;
                        wr      = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (fin_basic) begin
            if (32'(n_cs) >= 32'(CSID_SLOTS)) begin
                res_v            = 1'b1;
                res.kind         = KIND_ERROR;
                res.chunk_stream = n_cs;
                n_phase          = PH_HALT;
            end else begin
                o_rd_en = 1'b1;
                n_ld    = 1'b1;
                n_cnt   = '0;
                n_phase = (hdr_len(n_fmt) == 4'd0) ? PH_LOOKUP : PH_MSG;
            end
        end

        if (fin_msg) begin
            if (r_fmt <= 2'd1) begin
                n_ctx.length = n_hlen;
                n_ctx.offset = '0;
                n_ctx.mtype  = n_htype;
            end
            if (r_fmt == 2'd0) begin
                n_ctx.stream = n_hstream;
            end
            n_hext = '0;
            n_cnt  = '0;
            if (n_htime == TIME_EXT || n_ctx.stamp >= STAMP_EXT) begin
                n_phase = PH_EXT;
            end else begin
                fin_hdr = 1'b1;
            end
        end

        if (fin_hdr) begin
            if (n_ctx.offset == 24'd0) begin
                if (r_fmt == 2'd0) begin
                    n_ctx.mtime    = '0;
                    n_ctx.stamp    = {8'd0, n_htime};
                    n_ctx.extended = n_hext;
                end else if (n_ctx.stamp >= STAMP_EXT) begin
                    n_ctx.extended = n_ctx.extended + n_hext;
                end else begin
                    n_ctx.stamp = n_ctx.stamp + {8'd0, n_htime};
                end
            end
            remain = (n_ctx.offset < n_ctx.length) ? n_ctx.length - n_ctx.offset : '0;
            if (remain == 24'd0) begin
                add = (n_ctx.stamp >= STAMP_EXT) ? n_ctx.extended : n_ctx.stamp;
                n_ctx.mtime        = n_ctx.mtime + add;
                res_v              = 1'b1;
                res.kind           = KIND_EMPTY;
                res.chunk_stream   = r_cs;
                res.last           = 1'b1;
                res.message_length = n_ctx.length;
                res.message_type   = n_ctx.mtype;
                res.message_stream = n_ctx.stream;
                res.message_time   = n_ctx.mtime;
                n_ctx.offset       = '0;
                n_ctx.stamp        = '0;
                n_ctx.extended     = '0;
                n_phase            = PH_BASIC;
                wr                 = 1'b1;
            end else begin
                lim     = (r_csize == 24'd0) ? 24'd1 : r_csize;
                n_left  = (remain < lim) ? remain : lim;
                n_phase = PH_BODY;
            end
        end
    end

    assign o_rd_addr = n_cs[AW-1:0];
    assign o_wr_en   = wr;
    assign o_wr_addr = r_cs[AW-1:0];
    assign o_wr_data = n_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BASIC;
            r_cnt    <= '0;
            r_fmt    <= '0;
            r_cs     <= '0;
            r_ld     <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_valid  <= '0;
            r_csize  <= CHUNK_MAX_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_fmt   <= n_fmt;
            r_cs    <= n_cs;
            r_ld    <= n_ld;
            if (o_rd_en) begin
                r_rd_ok <= r_valid[o_rd_addr];
            end
            if (wr) begin
                r_valid[o_wr_addr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_csize <= i_cfg_data;
            end
            if (space) begin
                r_ovalid <= res_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_htime   <= n_htime;
        r_hlen    <= n_hlen;
        r_htype   <= n_htype;
        r_hstream <= n_hstream;
        r_hext    <= n_hext;
        r_left    <= n_left;
        r_ctx     <= n_ctx;
        if (space) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

@@ design/rcd_checker.sv @@
`timescale 1ns / 1ps
`include "rtmp_chunk_deframer_top_macros.svh"
module rcd_checker
    import rcd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] o_m_tdata,
    input logic [1:0]         o_m_tuser,
    input logic               o_m_tlast
);

    `RCD_ASSERT_NEXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `RCD_ASSERT_NEXT(a_halt, o_m_tvalid && i_m_tready && o_m_tuser == KIND_ERROR, !o_m_tvalid)
    `RCD_ASSERT_NOW(a_empty, o_m_tvalid && o_m_tuser == KIND_EMPTY, o_m_tlast && o_m_tdata[48:17] == 32'd0)
    `RCD_ASSERT_NOW(a_mid, o_m_tvalid && !o_m_tlast, o_m_tdata[144:49] == 96'd0)

endmodule

bind rtmp_chunk_deframer_top rcd_checker u_rcd_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import rcd_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        P_BASIC, P_ID2, P_ID3A, P_ID3B, P_MSG, P_EXT, P_BODY, P_HALT
    } t_phase;

    typedef struct {
        bit          is_cfg;
        logic [23:0] val;
        int          need;
    } t_pending;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [23:0]        cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    rtmp_chunk_deframer_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    t_pending byte_q[$];
    t_result  expected_q[$];
    int       fails = 0;
    int       seen = 0;
    int       sent = 0;

    // Parser shadow state
    logic [23:0] chunk_sz;
    t_phase      phase;
    int          hcount;
    logic [1:0]  hfmt;
    logic [23:0] htime, hlen;
    logic [7:0]  htype;
    logic [31:0] hstrm, hext;
    logic [16:0] cur_cs;
    logic [23:0] left;
    logic [23:0] c_len[SLOTS], c_off[SLOTS];
    logic [7:0]  c_type[SLOTS];
    logic [31:0] c_strm[SLOTS], c_stamp[SLOTS], c_ext[SLOTS], c_time[SLOTS];

    function automatic int hdr_bytes(input logic [1:0] f);
        case (f)
            2'd0:    return 11;
            2'd1:    return 7;
            2'd2:    return 3;
            default: return 0;
        endcase
    endfunction

    task automatic close_msg(input int cs, input t_kind k, input logic [7:0] b,
                             input logic [23:0] off, output t_result r);
        c_time[cs] = c_time[cs] + ((c_stamp[cs] >= STAMP_EXT) ? c_ext[cs] : c_stamp[cs]);
        r = '{k, cur_cs, b, off, 1'b1, c_len[cs], c_type[cs], c_strm[cs], c_time[cs]};
        c_off[cs] = '0;
        c_stamp[cs] = '0;
        c_ext[cs] = '0;
    endtask

    task automatic header_done(output bit got, output t_result r);
        int cs;
        logic [23:0] remain, lim;
        cs = int'(cur_cs);
        got = 0;
        if (c_off[cs] == 0) begin
            if (hfmt == 2'd0) begin
                c_time[cs] = '0;
                c_stamp[cs] = {8'd0, htime};
                c_ext[cs] = hext;
            end else if (c_stamp[cs] >= STAMP_EXT) begin
                c_ext[cs] = c_ext[cs] + hext;
            end else begin
                c_stamp[cs] = c_stamp[cs] + {8'd0, htime};
            end
        end
        remain = (c_off[cs] < c_len[cs]) ? c_len[cs] - c_off[cs] : '0;
        if (remain == 0) begin
            close_msg(cs, KIND_EMPTY, 8'd0, 24'd0, r);
            got = 1;
            phase = P_BASIC;
        end else begin
            lim = (chunk_sz == 0) ? 24'd1 : chunk_sz;
            left = (remain < lim) ? remain : lim;
            phase = P_BODY;
        end
    endtask

    task automatic msg_header_done(output bit got, output t_result r);
        int cs;
        cs = int'(cur_cs);
        got = 0;
        if (hfmt <= 2'd1) begin
            c_len[cs] = hlen;
            c_off[cs] = '0;
            c_type[cs] = htype;
        end
        if (hfmt == 2'd0) c_strm[cs] = hstrm;
        hext = '0;
        hcount = 0;
        if (htime >= TIME_EXT || c_stamp[cs] >= STAMP_EXT) phase = P_EXT;
        else header_done(got, r);
    endtask

    task automatic basic_done(output bit got, output t_result r);
        got = 0;
        if (cur_cs >= SLOTS) begin
            r = '{KIND_ERROR, cur_cs, 8'd0, 24'd0, 1'b0, 24'd0, 8'd0, 32'd0, 32'd0};
            got = 1;
            phase = P_HALT;
        end else begin
            hcount = 0;
            if (hdr_bytes(hfmt) == 0) msg_header_done(got, r);
            else phase = P_MSG;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, output bit got, output t_result r);
        int cs;
        logic [23:0] off;
        got = 0;
        case (phase)
            P_BASIC: begin
                hfmt = b[7:6];
                htime = '0; hlen = '0; htype = '0; hstrm = '0; hext = '0;
                cur_cs = {11'd0, b[5:0]};
                if (cur_cs == 0) phase = P_ID2;
                else if (cur_cs == 1) phase = P_ID3A;
                else basic_done(got, r);
            end
            P_ID2: begin
                cur_cs = CS_BASE + 17'(b);
                basic_done(got, r);
            end
            P_ID3A: begin
                cur_cs = CS_BASE + 17'(b);
                phase = P_ID3B;
            end
            P_ID3B: begin
                cur_cs = cur_cs + {1'b0, b, 8'd0};
                basic_done(got, r);
            end
            P_MSG: begin
                if (hcount < 3) htime = {htime[15:0], b};
                else if (hcount < 6) hlen = {hlen[15:0], b};
                else if (hcount == 6) htype = b;
                else hstrm = hstrm | (32'(b) << (8 * (hcount - 7)));
                hcount++;
                if (hcount >= hdr_bytes(hfmt)) msg_header_done(got, r);
            end
            P_EXT: begin
                hext = {hext[23:0], b};
                hcount++;
                if (hcount >= 4) header_done(got, r);
            end
            P_BODY: begin
                cs = int'(cur_cs);
                off = c_off[cs];
                c_off[cs] = off + 24'd1;
                left = left - 24'd1;
                got = 1;
                if (32'(off) + 1 >= 32'(c_len[cs])) begin
                    close_msg(cs, KIND_PAYLOAD, b, off, r);
                    phase = P_BASIC;
                end else begin
                    r = '{KIND_PAYLOAD, cur_cs, b, off, 1'b0, 24'd0, 8'd0, 32'd0, 32'd0};
                    if (left == 0) phase = P_BASIC;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send(input logic [7:0] b);
        bit got;
        t_result r;
        byte_q.push_back('{1'b0, {16'd0, b}, 0});
        parse_byte(b, got, r);
        if (got) expected_q.push_back(r);
        sent++;
    endtask

    // hold the write until every result caused so far has left the block
    task automatic set_chunk(input logic [23:0] v);
        byte_q.push_back('{1'b1, v, expected_q.size()});
        chunk_sz = v;
    endtask

    task automatic send_header(input int cs, input logic [1:0] f, input logic [23:0] len,
                               input logic [23:0] tstamp);
        logic [31:0] strm;
        strm = $urandom;
        send({f, cs[5:0]});
        if (f != 2'd3) begin
            send(tstamp[23:16]); send(tstamp[15:8]); send(tstamp[7:0]);
        end
        if (f <= 2'd1) begin
            send(len[23:16]); send(len[15:8]); send(len[7:0]);
            send(8'($urandom_range(0, 255)));
        end
        if (f == 2'd0) begin
            send(strm[7:0]); send(strm[15:8]); send(strm[23:16]); send(strm[31:24]);
        end
    endtask

    function automatic logic [23:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return 24'($urandom_range(0, 2));
            1:       return 24'($urandom_range(100, 300));
            default: return 24'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [23:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return TIME_EXT;
            1:       return 24'($urandom_range(0, 24'hff_fffe));
            default: return 24'($urandom_range(0, 2000));
        endcase
    endfunction

    // One message with continuation chunks; a restart header may cut in.
    task automatic send_message(input int cs, input logic [1:0] f);
        logic [1:0] cf;
        send_header(cs, f, pick_len(), pick_time());
        forever begin
            while (phase == P_EXT || phase == P_BODY) send(8'($urandom_range(0, 255)));
            if (c_off[cs] == 0) break;
            case ($urandom_range(0, 19))
                0:       cf = 2'($urandom_range(0, 1));
                1, 2:    cf = 2'd2;
                default: cf = 2'd3;
            endcase
            send_header(cs, cf, pick_len(), pick_time());
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        send({2'($urandom_range(0, 3)), 6'($urandom_range(2, 63))});
        repeat (n) begin
            if (phase == P_BASIC) break;
            send(8'($urandom_range(0, 255)));
        end
        while (phase == P_EXT || phase == P_BODY) send(8'($urandom_range(0, 255)));
        // finish any header left open so the next message starts cleanly
        while (phase != P_BASIC) send(8'($urandom_range(0, 255)));
    endtask

    task automatic build_stimulus();
        logic [23:0] sizes[5];
        int goal;
        chunk_sz = CHUNK_MAX_RST;
        phase = P_BASIC;
        hcount = 0; hfmt = '0; htime = '0; hlen = '0; htype = '0;
        hstrm = '0; hext = '0; cur_cs = '0; left = '0;
        for (int i = 0; i < SLOTS; i++) begin
            c_len[i] = '0; c_off[i] = '0; c_type[i] = '0; c_strm[i] = '0;
            c_stamp[i] = '0; c_ext[i] = '0; c_time[i] = '0;
        end
        // directed: every format, empty message, extreme ids
        send_header(2, 2'd0, 24'd3, 24'd10);
        send(8'h00); send(8'hff); send(8'h5a);
        send_header(63, 2'd0, 24'd0, 24'd0);
        send_header(2, 2'd1, 24'd1, 24'd5);
        send(8'ha5);
        send_header(2, 2'd2, 24'd0, 24'd7);
        send(8'h01);
        send_header(2, 2'd3, 24'd0, 24'd0);
        send(8'hfe);
        send_message(5, 2'd0);
        sizes = '{24'd1, 24'd0, 24'hff_ffff, 24'd7, 24'd3};
        foreach (sizes[p]) begin
            set_chunk(sizes[p]);
            goal = sent + 190;
            while (sent < goal) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else send_message($urandom_range(2, 63), 2'($urandom_range(0, 3)));
            end
        end
        // out-of-range id halts the parser; trailing bytes are ignored
        if ($urandom_range(0, 1)) begin
            send({2'($urandom_range(0, 3)), 6'd0});
            send(8'($urandom_range(0, 255)));
        end else begin
            send({2'($urandom_range(0, 3)), 6'd1});
            send(8'($urandom_range(0, 255)));
            send(8'($urandom_range(0, 255)));
        end
        send(8'($urandom_range(0, 255)));
        send(8'($urandom_range(0, 255)));
    endtask

    // Sender: bursts with gaps; configuration only once the output has gone quiet
    int gap = 0, burst = 0, quiet = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
            quiet <= 0;
        end else begin
            quiet <= (byte_q.size() != 0 && byte_q[0].is_cfg && seen == byte_q[0].need
                      && !m_tvalid) ? quiet + 1 : 0;
            if (cfg_valid) begin
                if (cfg_ready) begin
                    void'(byte_q.pop_front());
                    cfg_valid <= 1'b0;
                end
            end else if (!(s_tvalid && !s_tready)) begin
                if (s_tvalid) void'(byte_q.pop_front());
                if (byte_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (byte_q[0].is_cfg) begin
                    s_tvalid <= 1'b0;
                    if (!s_tvalid && quiet >= 10) begin
                        cfg_valid <= 1'b1;
                        cfg_data <= byte_q[0].val;
                    end
                end else if (gap > 0) begin
                    gap <= gap - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= byte_q[0].val[7:0];
                    if (burst == 0) begin
                        burst <= $urandom_range(1, 40);
                        gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst <= burst - 1;
                    end
                end
            end
        end
    end

    // Receiver: stall modes plus one long hold-off to back up the input
    int hold = 0, tick = 0, mode = 0;
    bit held = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            tick <= tick + 1;
            if (tick % 64 == 0) mode <= $urandom_range(0, 2);
            if (hold > 0) begin
                hold <= hold - 1;
                m_tready <= 1'b0;
            end else if (!held && seen >= 150) begin
                held <= 1;
                hold <= 300;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk) begin
        t_result w;
        if (rst_n && m_tvalid && m_tready) begin
            seen <= seen + 1;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transfer tdata %0h", $realtime, m_tdata);
                fails++;
            end else begin
                w = expected_q.pop_front();
                check_field("result_kind", 64'(w.kind), 64'(m_tuser));
                check_field("chunk_stream", 64'(w.chunk_stream), 64'(m_tdata[16:0]));
                check_field("payload_byte", 64'(w.payload_byte), 64'(m_tdata[24:17]));
                check_field("byte_offset", 64'(w.byte_offset), 64'(m_tdata[48:25]));
                check_field("last", 64'(w.last), 64'(m_tlast));
                check_field("message_length", 64'(w.message_length), 64'(m_tdata[72:49]));
                check_field("message_type", 64'(w.message_type), 64'(m_tdata[80:73]));
                check_field("message_stream", 64'(w.message_stream), 64'(m_tdata[112:81]));
                check_field("message_time", 64'(w.message_time), 64'(m_tdata[144:113]));
            end
        end
    end

    int cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (byte_q.size() == 0 && expected_q.size() == 0);
        repeat (20) @(posedge clk);
        if (fails == 0 && expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (expected_q.size() != 0)
                $display("%0t: %0d results never arrived", $realtime, expected_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
